### design/mrm_pkg.sv
// package: constants, types and helper functions of the message ring mailbox
package mrm_pkg;

   localparam int RING_WORDS = 256;
   localparam int PTR_W      = $clog2(RING_WORDS);
   // room for a message size in words plus header, and for the ring depth itself
   localparam int CNT_W      = 17;
   // ceil(65535 / 4) payload words at most
   localparam int WORDS_W    = 15;

   typedef enum logic [1:0] {
      OP_SEND_HDR  = 2'd0,
      OP_SEND_WORD = 2'd1,
      OP_RECV_HDR  = 2'd2,
      OP_RECV_WORD = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NOSPACE  = 3'd1,
      ST_TOOLARGE = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_SMALL    = 3'd4,
      ST_SEQ      = 3'd5
   } status_type;

   typedef logic [PTR_W-1:0] ptr_type;

   typedef struct packed {
      op_type      operation;
      logic [15:0] length;
      logic [15:0] tag;
      logic [31:0] data_word;
      logic [15:0] capacity;
   } req_item_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] msg_length;
      logic [15:0] msg_tag;
      logic [31:0] read_word;
      logic        last;
      logic        message_published;
      logic        ack_to_sender;
   } rsp_item_type;

   typedef struct packed {
      logic        en;
      ptr_type     addr;
      logic [31:0] data;
   } mem_wr_type;

   typedef struct packed {
      ptr_type pub;
      ptr_type pend;
   } rd_pos_type;

   function automatic ptr_type next_pos(input ptr_type p);
      ptr_type r;
      if (p == PTR_W'(RING_WORDS - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   // byte count rounded up to whole 32-bit words
   function automatic logic [WORDS_W-1:0] words_of(input logic [15:0] bytes);
      logic [16:0] sum;
      sum = {1'b0, bytes} + 17'd3;
      return sum[16:2];
   endfunction

endpackage

### design/mrm_if.sv
// channel interfaces: request and response with valid/ready handshake
interface mrm_req_if
   import mrm_pkg::*;
;
   logic        valid;
   logic        ready;
   op_type      operation;
   logic [15:0] length;
   logic [15:0] tag;
   logic [31:0] data_word;
   logic [15:0] capacity;

   modport source (output valid, operation, length, tag, data_word, capacity,
                   input ready);
   modport sink   (input valid, operation, length, tag, data_word, capacity,
                   output ready);
endinterface

interface mrm_rsp_if
   import mrm_pkg::*;
;
   logic        valid;
   logic        ready;
   status_type  status;
   logic [15:0] msg_length;
   logic [15:0] msg_tag;
   logic [31:0] read_word;
   logic        last;
   logic        message_published;
   logic        ack_to_sender;

   modport source (output valid, status, msg_length, msg_tag, read_word, last,
                   message_published, ack_to_sender, input ready);
   modport sink   (input valid, status, msg_length, msg_tag, read_word, last,
                   message_published, ack_to_sender, output ready);
endinterface

### design/mrm_ram.sv
// ring word memory: one write port, one registered read port with write bypass
module mrm_ram
   import mrm_pkg::*;
(
   input  logic        clock,
   input  mem_wr_type  wr,
   input  logic        rd_en,
   input  ptr_type     rd_addr,
   output logic [31:0] rd_data
);

   logic [31:0] ring_store_ff [RING_WORDS];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         ring_store_ff[wr.addr] <= wr.data;
      end
   end

   // a word written in the same cycle is returned directly
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr.en && (wr.addr == rd_addr)) begin
            rd_data_ff <= wr.data;
         end else begin
            rd_data_ff <= ring_store_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/mrm_core.sv
// ring positions, word counters, ack mark and the per-request decision logic
module mrm_core
   import mrm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_item_type item,
   input  logic [31:0]  rd_data,
   output rsp_item_type result,
   output mem_wr_type   mem_wr,
   output rd_pos_type   rd_pos
);

   ptr_type             pub_wr_ff, pub_wr_in;
   ptr_type             pend_wr_ff, pend_wr_in;
   ptr_type             pub_rd_ff, pub_rd_in;
   ptr_type             pend_rd_ff, pend_rd_in;
   logic [WORDS_W-1:0]  send_left_ff, send_left_in;
   logic [WORDS_W-1:0]  recv_left_ff, recv_left_in;
   logic                ack_valid_ff, ack_valid_in;
   ptr_type             ack_pos_ff, ack_pos_in;
   mem_wr_type          wr;

   always_comb begin
      logic [WORDS_W-1:0] items;
      logic [CNT_W-1:0]   total;
      logic [CNT_W-1:0]   avail;
      logic [15:0]        hdr_size;
      logic [WORDS_W-1:0] hdr_words;

      pub_wr_in    = pub_wr_ff;
      pend_wr_in   = pend_wr_ff;
      pub_rd_in    = pub_rd_ff;
      pend_rd_in   = pend_rd_ff;
      send_left_in = send_left_ff;
      recv_left_in = recv_left_ff;
      ack_valid_in = ack_valid_ff;
      ack_pos_in   = ack_pos_ff;
      result       = '0;
      result.status = ST_OK;
      wr           = '0;

      items     = words_of(item.length);
      total     = CNT_W'(items) + 1'b1;
      hdr_size  = rd_data[15:0];
      hdr_words = words_of(hdr_size);
      if (pub_rd_ff <= pub_wr_ff) begin
         avail = CNT_W'(RING_WORDS) - 1'b1 - (CNT_W'(pub_wr_ff) - CNT_W'(pub_rd_ff));
      end else begin
         avail = CNT_W'(pub_rd_ff) - CNT_W'(pub_wr_ff) - 1'b1;
      end

      case (item.operation)
         OP_SEND_HDR: begin
            if (send_left_ff != '0) begin
               result.status = ST_SEQ;
            end else if (total >= CNT_W'(RING_WORDS)) begin
               result.status = ST_TOOLARGE;
            end else if (avail < total) begin
               result.status = ST_NOSPACE;
               ack_valid_in  = 1'b1;
               ack_pos_in    = pub_rd_ff;
            end else begin
               ack_valid_in = 1'b0;
               wr.en        = 1'b1;
               wr.addr      = pub_wr_ff;
               wr.data      = {item.tag, item.length};
               pend_wr_in   = next_pos(pub_wr_ff);
               send_left_in = items;
               if (items == '0) begin
                  pub_wr_in                = next_pos(pub_wr_ff);
                  result.last              = 1'b1;
                  result.message_published = 1'b1;
               end
            end
         end
         OP_SEND_WORD: begin
            if (send_left_ff == '0) begin
               result.status = ST_SEQ;
            end else begin
               wr.en        = 1'b1;
               wr.addr      = pend_wr_ff;
               wr.data      = item.data_word;
               pend_wr_in   = next_pos(pend_wr_ff);
               send_left_in = send_left_ff - 1'b1;
               if (send_left_ff == WORDS_W'(1)) begin
                  pub_wr_in                = next_pos(pend_wr_ff);
                  result.last              = 1'b1;
                  result.message_published = 1'b1;
               end
            end
         end
         OP_RECV_HDR: begin
            if (recv_left_ff != '0) begin
               result.status = ST_SEQ;
            end else if (pub_rd_ff == pub_wr_ff) begin
               result.status = ST_EMPTY;
            end else begin
               result.msg_length = hdr_size;
               if (item.capacity < hdr_size) begin
                  result.status = ST_SMALL;
               end else begin
                  result.msg_tag = rd_data[31:16];
                  pend_rd_in     = next_pos(pub_rd_ff);
                  recv_left_in   = hdr_words;
                  if (hdr_words == '0) begin
                     pub_rd_in   = next_pos(pub_rd_ff);
                     result.last = 1'b1;
                     if (ack_valid_ff && (ack_pos_ff == pub_rd_ff)) begin
                        result.ack_to_sender = 1'b1;
                        ack_valid_in         = 1'b0;
                     end
                  end
               end
            end
         end
         OP_RECV_WORD: begin
            if (recv_left_ff == '0) begin
               result.status = ST_SEQ;
            end else begin
               result.read_word = rd_data;
               pend_rd_in       = next_pos(pend_rd_ff);
               recv_left_in     = recv_left_ff - 1'b1;
               if (recv_left_ff == WORDS_W'(1)) begin
                  pub_rd_in   = next_pos(pend_rd_ff);
                  result.last = 1'b1;
                  if (ack_valid_ff && (ack_pos_ff == pub_rd_ff)) begin
                     result.ack_to_sender = 1'b1;
                     ack_valid_in         = 1'b0;
                  end
               end
            end
         end
         default: begin
            result.status = ST_SEQ;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pub_wr_ff    <= '0;
         pend_wr_ff   <= '0;
         pub_rd_ff    <= '0;
         pend_rd_ff   <= '0;
         send_left_ff <= '0;
         recv_left_ff <= '0;
         ack_valid_ff <= 1'b0;
         ack_pos_ff   <= '0;
      end else if (fire) begin
         pub_wr_ff    <= pub_wr_in;
         pend_wr_ff   <= pend_wr_in;
         pub_rd_ff    <= pub_rd_in;
         pend_rd_ff   <= pend_rd_in;
         send_left_ff <= send_left_in;
         recv_left_ff <= recv_left_in;
         ack_valid_ff <= ack_valid_in;
         ack_pos_ff   <= ack_pos_in;
      end
   end

   assign mem_wr.en   = fire && wr.en;
   assign mem_wr.addr = wr.addr;
   assign mem_wr.data = wr.data;

   // read positions as they stand after this cycle, for the next request's read
   assign rd_pos.pub  = fire ? pub_rd_in  : pub_rd_ff;
   assign rd_pos.pend = fire ? pend_rd_in : pend_rd_ff;

   a_ack_on_recv_done: assert property (@(posedge clock) disable iff (reset)
      fire && result.ack_to_sender |->
         result.last && (item.operation == OP_RECV_HDR || item.operation == OP_RECV_WORD))
      else $error("ack raised outside a completed receive");

   a_write_only_on_send: assert property (@(posedge clock) disable iff (reset)
      mem_wr.en |-> (item.operation == OP_SEND_HDR || item.operation == OP_SEND_WORD))
      else $error("ring write from a receive request");

   a_no_open_send: assert property (@(posedge clock) disable iff (reset)
      send_left_ff == '0 |-> pend_wr_ff == pub_wr_ff)
      else $error("write positions differ with no send open");

   a_no_open_recv: assert property (@(posedge clock) disable iff (reset)
      recv_left_ff == '0 |-> pend_rd_ff == pub_rd_ff)
      else $error("read positions differ with no receive open");

   a_publish_commits: assert property (@(posedge clock) disable iff (reset)
      fire && result.message_published |=> pub_wr_ff == pend_wr_ff)
      else $error("published write position not caught up");

endmodule

### design/message_ring_mailbox_top.sv
// top level of the message ring mailbox: input stage, ring memory, core and result register
//
// usage
//   req_ch carries one request per handshake: operation (send header, send payload
//   word, receive header, receive payload word) with length, tag, data_word and
//   capacity; fields an operation does not use are ignored
//   rsp_ch returns exactly one response per request, in request order: status,
//   msg_length, msg_tag, read_word, last, message_published, ack_to_sender
// throughput
//   a request is registered in the input stage, its response in the result register
//   one request per cycle sustained while the receiver takes responses; the ring memory
//   read for a request is issued as it is accepted, so its data is ready in the input stage
// reset
//   synchronous, active high; clears all ring positions, counters and the ack mark
//   and empties both stages; the ring words themselves are not cleared, nothing
//   reads them before they are written
// receiver stall
//   a held response keeps the response register; an empty input stage still takes one
//   more request, then req_ch.ready drops until the response is taken
module message_ring_mailbox_top
   import mrm_pkg::*;
(
   input logic       clock,
   input logic       reset,
   mrm_req_if.sink   req_ch,
   mrm_rsp_if.source rsp_ch
);

   // input stage
   logic         s1_valid_ff, s1_valid_in;
   req_item_type s1_item_ff;
   req_item_type req_item;
   logic         s1_fire;
   logic         req_take;

   // result register
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_ff;

   // core and memory
   rsp_item_type result;
   mem_wr_type   mem_wr;
   rd_pos_type   rd_pos;
   ptr_type      rd_addr;
   logic [31:0]  rd_data;

   // stage moves on when the result register is free or being drained
   assign s1_fire  = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_take = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !s1_valid_ff || s1_fire;

   assign req_item.operation = req_ch.operation;
   assign req_item.length    = req_ch.length;
   assign req_item.tag       = req_ch.tag;
   assign req_item.data_word = req_ch.data_word;
   assign req_item.capacity  = req_ch.capacity;

   // receive header reads the head header, everything else the next payload word
   assign rd_addr = (req_ch.operation == OP_RECV_HDR) ? rd_pos.pub : rd_pos.pend;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (s1_fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= req_item;
      end
      if (s1_fire) begin
         out_ff <= result;
      end
   end

   mrm_ram u_ram (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_en   (req_take),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mrm_core u_core (
      .clock   (clock),
      .reset   (reset),
      .fire    (s1_fire),
      .item    (s1_item_ff),
      .rd_data (rd_data),
      .result  (result),
      .mem_wr  (mem_wr),
      .rd_pos  (rd_pos)
   );

   assign rsp_ch.valid             = out_valid_ff;
   assign rsp_ch.status            = out_ff.status;
   assign rsp_ch.msg_length        = out_ff.msg_length;
   assign rsp_ch.msg_tag           = out_ff.msg_tag;
   assign rsp_ch.read_word         = out_ff.read_word;
   assign rsp_ch.last              = out_ff.last;
   assign rsp_ch.message_published = out_ff.message_published;
   assign rsp_ch.ack_to_sender     = out_ff.ack_to_sender;

endmodule
